@@ sv/lxrg_pkg.sv @@
package lxrg_pkg;

  localparam int WORD_BITS = 15;
  localparam int INDEX_W   = 8;
  localparam int RANGE_W   = WORD_BITS + 1;
  localparam int DIV_CNT_W = $clog2(RANGE_W);

  localparam logic [RANGE_W-1:0]   WORD_SPAN = RANGE_W'(1) << WORD_BITS;
  localparam logic [WORD_BITS-1:0] WORD_MASK = {WORD_BITS{1'b1}};

  // Conditioned seed positions are COND_FIRST + COND_STEP * k for k below WORD_BITS.
  localparam int COND_FIRST = 14;
  localparam int COND_STEP  = 11;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NEXT    = 2'd1;
  localparam logic [1:0] OP_BOUNDED = 2'd2;

  // A seed word at a conditioned position keeps only the bits below its
  // leading bit, and that leading bit is forced to one.
  function automatic logic [WORD_BITS-1:0] cond_seed(input logic [INDEX_W-1:0] idx,
                                                     input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] res;
    logic [WORD_BITS-1:0] top;
    res = w;
    for (int k = 0; k < WORD_BITS; k++) begin
      top = WORD_BITS'(1) << (WORD_BITS - 1 - k);
      if (idx == INDEX_W'(COND_FIRST + COND_STEP * k)) begin
        res = (w & (top - WORD_BITS'(1))) | top;
      end
    end
    return res;
  endfunction

endpackage

@@ sv/lxrg_ram.sv @@
module lxrg_ram #(
  parameter int WIDTH  = 15,
  parameter int DEPTH  = 250,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/lagged_xor_random_generator.sv @@
// Lagged-XOR random generator over a table of TABLE_WORDS words.
// Input channel (in_valid/in_ready) takes one item per transaction: op selects
// a seed load (seed_index, seed_word), a plain draw, or a draw bounded below
// range_limit. Every table word must be loaded before the first draw.
// Output channel (out_valid/out_ready) carries one value for each draw; a load
// produces nothing. The result sits in an output register until taken.
// A load completes in its accept cycle. A plain draw passes S_RD_Q, S_WR and
// S_OUT to reach the output register, and the next item is taken only back in
// S_IDLE, so plain draws do not overlap. The single table read port is used
// twice (the word at the pointer, then the word LAG positions ahead) and then
// the XOR is written back.
// A bounded draw first runs the RANGE_W-bit bit-serial remainder unit in S_PREP
// to find the rejection limit, then S_RD_P, S_RD_Q and S_WR per raw draw
// (repeated while draws are rejected, at most 4 * TABLE_WORDS raw draws), then
// S_MOD for the final remainder and S_OUT to reach the output register.
// The block takes a new item only between items, so a stalled receiver holds
// the block once the next result is ready. Reset clears the pointer and the
// output valid; the table contents are not cleared.
module lagged_xor_random_generator #(
  parameter int TABLE_WORDS = 250,
  parameter int LAG         = 103
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [lxrg_pkg::INDEX_W-1:0]    seed_index,
  input  logic [lxrg_pkg::WORD_BITS-1:0]  seed_word,
  input  logic [lxrg_pkg::RANGE_W-1:0]    range_limit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lxrg_pkg::WORD_BITS-1:0]  value
);

  localparam int PTR_W   = $clog2(TABLE_WORDS);
  localparam int LAG_MOD = LAG % TABLE_WORDS;
  localparam int TRY_W   = $clog2(4 * TABLE_WORDS);
  localparam int WB      = lxrg_pkg::WORD_BITS;
  localparam int RW      = lxrg_pkg::RANGE_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_RD_P = 7'b0000100,
    S_RD_Q = 7'b0001000,
    S_WR   = 7'b0010000,
    S_MOD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                           state;
  logic [PTR_W-1:0]                 pointer;
  logic                             is_bounded;
  logic [RW-1:0]                    rng;
  logic [RW-1:0]                    dvd;
  logic [RW-1:0]                    rem;
  logic [lxrg_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [WB-1:0]                    limit;
  logic [TRY_W-1:0]                 tries;
  logic [WB-1:0]                    word_p;
  logic [WB-1:0]                    result;

  logic                             out_free;
  logic [PTR_W-1:0]                 ptr_inc;
  logic [PTR_W:0]                   q_sum;
  logic [PTR_W-1:0]                 q_addr;
  logic [WB-1:0]                    draw;
  logic [RW:0]                      rem_sh;
  logic [RW-1:0]                    rem_step;
  logic                             div_last;
  logic [RW-1:0]                    rng_eff;
  logic                             seed_in_range;
  logic                             ram_wr_en;
  logic [PTR_W-1:0]                 ram_wr_addr;
  logic [WB-1:0]                    ram_wr_data;
  logic [PTR_W-1:0]                 ram_rd_addr;
  logic [WB-1:0]                    ram_rd_data;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ptr_inc = (pointer == PTR_W'(TABLE_WORDS - 1)) ? '0 : pointer + PTR_W'(1);
    q_sum   = {1'b0, pointer} + (PTR_W + 1)'(LAG_MOD);
    if (q_sum >= (PTR_W + 1)'(TABLE_WORDS)) begin
      q_addr = PTR_W'(q_sum - (PTR_W + 1)'(TABLE_WORDS));
    end else begin
      q_addr = PTR_W'(q_sum);
    end
  end

  assign draw = word_p ^ ram_rd_data;

  // One restoring step of the remainder unit: shift in the next dividend bit.
  always_comb begin
    rem_sh = {rem, dvd[RW-1]};
    if (rem_sh >= {1'b0, rng}) begin
      rem_step = RW'(rem_sh - {1'b0, rng});
    end else begin
      rem_step = RW'(rem_sh);
    end
    div_last = (div_cnt == lxrg_pkg::DIV_CNT_W'(RW - 1));
  end

  // A zero range or one above the word span means the full word span.
  always_comb begin
    if (range_limit == '0 || range_limit > lxrg_pkg::WORD_SPAN) begin
      rng_eff = lxrg_pkg::WORD_SPAN;
    end else begin
      rng_eff = range_limit;
    end
  end

  assign seed_in_range = (11'(seed_index) < 11'(TABLE_WORDS));

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = PTR_W'(seed_index);
    ram_wr_data = lxrg_pkg::cond_seed(seed_index, seed_word);
    if (state == S_WR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = pointer;
      ram_wr_data = draw;
    end else if (state == S_IDLE && in_valid && op == lxrg_pkg::OP_LOAD && seed_in_range) begin
      ram_wr_en = 1'b1;
    end
    ram_rd_addr = (state == S_RD_Q) ? q_addr : pointer;
  end

  lxrg_ram #(
    .WIDTH (WB),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pointer   <= '0;
      out_valid <= 1'b0;
    end else begin
      // In S_OUT the output register is refilled or held by the case below.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // The read of the word at the pointer is issued in this cycle.
          if (in_valid) begin
            case (op)
              lxrg_pkg::OP_LOAD: begin
                pointer <= '0;
              end
              lxrg_pkg::OP_NEXT: begin
                is_bounded <= 1'b0;
                state      <= S_RD_Q;
              end
              lxrg_pkg::OP_BOUNDED: begin
                is_bounded <= 1'b1;
                rng        <= rng_eff;
                dvd        <= lxrg_pkg::WORD_SPAN;
                rem        <= '0;
                div_cnt    <= '0;
                tries      <= '0;
                state      <= S_PREP;
              end
              default: begin
              end
            endcase
          end
        end
        S_PREP: begin
          rem     <= rem_step;
          dvd     <= dvd << 1;
          div_cnt <= div_cnt + lxrg_pkg::DIV_CNT_W'(1);
          if (div_last) begin
            limit <= lxrg_pkg::WORD_MASK - WB'(rem_step);
            state <= S_RD_P;
          end
        end
        S_RD_P: begin
          state <= S_RD_Q;
        end
        S_RD_Q: begin
          word_p <= ram_rd_data;
          state  <= S_WR;
        end
        S_WR: begin
          pointer <= ptr_inc;
          tries   <= tries + TRY_W'(1);
          if (!is_bounded) begin
            result <= draw;
            state  <= S_OUT;
          end else if (draw <= limit || tries == TRY_W'(4 * TABLE_WORDS - 1)) begin
            dvd     <= {1'b0, draw};
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_MOD;
          end else begin
            state <= S_RD_P;
          end
        end
        S_MOD: begin
          rem     <= rem_step;
          dvd     <= dvd << 1;
          div_cnt <= div_cnt + lxrg_pkg::DIV_CNT_W'(1);
          if (div_last) begin
            result <= WB'(rem_step);
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            value     <= result;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int TABLE_WORDS    = 250;
  localparam int LAG            = 103;
  localparam int TOTAL_REQUESTS = 700;
  localparam int IDLE_LIMIT     = 20000;
  localparam int DRAIN_CYCLES   = 40;

  // The block ignores this opcode.
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]                     op;
    logic [lxrg_pkg::INDEX_W-1:0]   index;
    logic [lxrg_pkg::WORD_BITS-1:0] word;
    logic [lxrg_pkg::RANGE_W-1:0]   bound;
  } gen_request_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     op = lxrg_pkg::OP_LOAD;
  logic [lxrg_pkg::INDEX_W-1:0]   seed_index = '0;
  logic [lxrg_pkg::WORD_BITS-1:0] seed_word = '0;
  logic [lxrg_pkg::RANGE_W-1:0]   range_limit = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [lxrg_pkg::WORD_BITS-1:0] value;

  gen_request_t                   pending_requests[$];
  gen_request_t                   next_request;
  logic [lxrg_pkg::WORD_BITS-1:0] expected_values[$];
  logic [lxrg_pkg::WORD_BITS-1:0] expected_word;

  // Mirror of the generator state.
  logic [lxrg_pkg::WORD_BITS-1:0] lag_words [TABLE_WORDS];
  int unsigned                    draw_pos = 0;

  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int idle_cycles = 0;
  int request_count = 0;

  lagged_xor_random_generator #(
    .TABLE_WORDS(TABLE_WORDS),
    .LAG(LAG)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .seed_index(seed_index),
    .seed_word(seed_word),
    .range_limit(range_limit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [lxrg_pkg::WORD_BITS-1:0] conditioned_word(
      int idx, logic [lxrg_pkg::WORD_BITS-1:0] w);
    int k;
    logic [lxrg_pkg::WORD_BITS-1:0] lead;
    if (idx >= lxrg_pkg::COND_FIRST && (idx - lxrg_pkg::COND_FIRST) % lxrg_pkg::COND_STEP == 0)
    begin
      k = (idx - lxrg_pkg::COND_FIRST) / lxrg_pkg::COND_STEP;
      if (k < lxrg_pkg::WORD_BITS) begin
        lead = lxrg_pkg::WORD_BITS'(1) << (lxrg_pkg::WORD_BITS - 1 - k);
        return (w & (lead - lxrg_pkg::WORD_BITS'(1))) | lead;
      end
    end
    return w;
  endfunction

  function automatic logic [lxrg_pkg::WORD_BITS-1:0] lagged_draw();
    int unsigned partner;
    logic [lxrg_pkg::WORD_BITS-1:0] mixed;
    partner = (draw_pos + LAG) % TABLE_WORDS;
    mixed = lag_words[draw_pos] ^ lag_words[partner];
    lag_words[draw_pos] = mixed;
    draw_pos = (draw_pos + 1) % TABLE_WORDS;
    return mixed;
  endfunction

  function automatic logic [lxrg_pkg::WORD_BITS-1:0] bounded_value(
      logic [lxrg_pkg::RANGE_W-1:0] bound);
    int unsigned span;
    int unsigned rng;
    int unsigned limit;
    int unsigned draw;
    span = int'(lxrg_pkg::WORD_SPAN);
    rng = 32'(bound);
    if (rng == 0 || rng > span) begin
      rng = span;
    end
    limit = int'(lxrg_pkg::WORD_MASK) - (span % rng);
    draw = 0;
    for (int tries = 0; tries < 4 * TABLE_WORDS; tries++) begin
      draw = 32'(lagged_draw());
      if (draw <= limit) begin
        break;
      end
    end
    return lxrg_pkg::WORD_BITS'(draw % rng);
  endfunction

  task automatic step_generator(gen_request_t req);
    case (req.op)
      lxrg_pkg::OP_LOAD: begin
        draw_pos = 0;
        if (req.index < TABLE_WORDS) begin
          lag_words[req.index] = conditioned_word(int'(req.index), req.word);
        end
      end
      lxrg_pkg::OP_NEXT: expected_values.push_back(lagged_draw());
      lxrg_pkg::OP_BOUNDED: expected_values.push_back(bounded_value(req.bound));
      default: ;
    endcase
  endtask

  task automatic add_request(logic [1:0] code, int idx, int word, int bound);
    gen_request_t req;
    req.op = code;
    req.index = lxrg_pkg::INDEX_W'(idx);
    req.word = lxrg_pkg::WORD_BITS'(word);
    req.bound = lxrg_pkg::RANGE_W'(bound);
    pending_requests.push_back(req);
    if (code != OP_NONE) begin
      request_count++;
    end
  endtask

  function automatic int random_bound();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 0;
      1: return $urandom_range(32769, 65535);
      2, 3, 4: return $urandom_range(1, 16);
      5: return 32768;
      default: return $urandom_range(1, 32768);
    endcase
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        step_generator('{op, seed_index, seed_word, range_limit});
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_request = pending_requests.pop_front();
          op <= next_request.op;
          seed_index <= next_request.index;
          seed_word <= next_request.word;
          range_limit <= next_request.bound;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls rotate among three modes of behaviour, including
  // stretches where it never stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      case ((cycle_count / 300) % 3)
        0: out_ready <= 1'b1;
        1: begin
          if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 3);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(5, 20);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Monitor: each result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d", $time, value);
        mismatches++;
      end else begin
        expected_word = expected_values.pop_front();
        if (value !== expected_word) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, expected_word, value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int seed;
    int pick;
    // Every table word is loaded before the first draw, including the
    // conditioned positions at their extremes and the first position past them.
    for (int i = 0; i < TABLE_WORDS; i++) begin
      case (i)
        0, 25, 179, 249: seed = 32'h7FFF;
        14, 168: seed = 0;
        default: seed = $urandom_range(0, 32767);
      endcase
      add_request(lxrg_pkg::OP_LOAD, i, seed, $urandom_range(0, 65535));
    end
    add_request(lxrg_pkg::OP_NEXT, $urandom_range(0, 255), $urandom_range(0, 32767), 0);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 1);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 2);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 3);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 0);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 32768);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 32769);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 65535);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 32767);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 16385);
    add_request(OP_NONE, 255, 32'h7FFF, 65535);
    add_request(lxrg_pkg::OP_NEXT, 255, 32'h7FFF, 65535);
    add_request(lxrg_pkg::OP_LOAD, 250, 32'h7FFF, 0);
    add_request(lxrg_pkg::OP_NEXT, 0, 0, 0);
    add_request(lxrg_pkg::OP_LOAD, 255, 0, 65535);
    add_request(lxrg_pkg::OP_LOAD, 100, 0, 0);
    add_request(lxrg_pkg::OP_NEXT, 0, 0, 0);
    add_request(lxrg_pkg::OP_LOAD, 14, 32'h7FFF, 0);
    add_request(lxrg_pkg::OP_BOUNDED, 0, 0, 7);

    // Draws with random content, reseeding now and then, plus out-of-range loads and
    // the ignored opcode; the table stays fully loaded so every draw reads defined words.
    while (request_count < TOTAL_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        add_request(lxrg_pkg::OP_NEXT, $urandom_range(0, 255), $urandom_range(0, 32767),
                    $urandom_range(0, 65535));
      end else if (pick < 80) begin
        add_request(lxrg_pkg::OP_BOUNDED, $urandom_range(0, 255), $urandom_range(0, 32767),
                    random_bound());
      end else if (pick < 90) begin
        add_request(lxrg_pkg::OP_LOAD, $urandom_range(0, TABLE_WORDS - 1),
                    $urandom_range(0, 32767), $urandom_range(0, 65535));
      end else if (pick < 94) begin
        add_request(lxrg_pkg::OP_LOAD, $urandom_range(TABLE_WORDS, 255),
                    $urandom_range(0, 32767), $urandom_range(0, 65535));
      end else begin
        add_request(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 32767),
                    $urandom_range(0, 65535));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sampling at the falling edge sees the driver and monitor updates settled.
    while (pending_requests.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    while (expected_values.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lxrg_pkg.sv
sv/lxrg_ram.sv
sv/lagged_xor_random_generator.sv
tb/sv/tb_top.sv
